// ===== rtl/core/pcr_pkg.sv =====
package pcr_pkg;

	// Width of one output group
	localparam int unsigned GroupBits = 5;
	// Default depth of the queue between front and back
	localparam int unsigned QueueDepthDefault = 2;

	// One prefix-code table entry: right-aligned code, length in bits (0 = unknown)
	typedef struct packed {
		logic [7:0] code;
		logic [3:0] len;
	} prefix_code_t;

	// Request handed from front to back: up to two results
	typedef struct packed {
		logic [1:0]           n_res;    // results in this request, 1 or 2
		logic [GroupBits-1:0] grp0;     // first group
		logic [GroupBits-1:0] grp1;     // second group (unused if newline tail)
		logic                 nl_tail;  // final result is the newline item
	} req_t;

	// Prefix-code table lookup
	function automatic prefix_code_t code_lookup(input logic [7:0] ch);
		prefix_code_t e;
		e = '{code: 8'h00, len: 4'd0};
		case (ch)
			8'h20: e = '{code: 8'h05, len: 4'd3};   // space
			8'h27: e = '{code: 8'h00, len: 4'd6};   // apostrophe
			8'h2C: e = '{code: 8'h03, len: 4'd6};   // comma
			8'h2D: e = '{code: 8'h91, len: 4'd8};   // hyphen
			8'h2E: e = '{code: 8'h11, len: 4'd6};   // period
			8'h3F: e = '{code: 8'h01, len: 4'd6};   // question mark
			8'h41: e = '{code: 8'h25, len: 4'd6};
			8'h42: e = '{code: 8'h9A, len: 4'd8};
			8'h43: e = '{code: 8'h05, len: 4'd4};
			8'h44: e = '{code: 8'h01, len: 4'd4};
			8'h45: e = '{code: 8'h06, len: 4'd3};
			8'h46: e = '{code: 8'h09, len: 4'd5};
			8'h47: e = '{code: 8'h9B, len: 4'd8};
			8'h48: e = '{code: 8'h10, len: 4'd6};
			8'h49: e = '{code: 8'h07, len: 4'd4};
			8'h4A: e = '{code: 8'h98, len: 4'd8};
			8'h4B: e = '{code: 8'h06, len: 4'd4};
			8'h4C: e = '{code: 8'h04, len: 4'd5};
			8'h4D: e = '{code: 8'h99, len: 4'd8};
			8'h4E: e = '{code: 8'h9E, len: 4'd8};
			8'h4F: e = '{code: 8'h05, len: 4'd5};
			8'h50: e = '{code: 8'h07, len: 4'd3};
			8'h51: e = '{code: 8'h9F, len: 4'd8};
			8'h52: e = '{code: 8'h08, len: 4'd4};
			8'h53: e = '{code: 8'h06, len: 4'd5};
			8'h54: e = '{code: 8'h07, len: 4'd5};
			8'h55: e = '{code: 8'h9C, len: 4'd8};
			8'h56: e = '{code: 8'h9D, len: 4'd8};
			8'h57: e = '{code: 8'h02, len: 4'd6};
			8'h58: e = '{code: 8'h92, len: 4'd8};
			8'h59: e = '{code: 8'h93, len: 4'd8};
			8'h5A: e = '{code: 8'h90, len: 4'd8};
			default: e = '{code: 8'h00, len: 4'd0};
		endcase
		return e;
	endfunction

	// 32-entry output alphabet
	function automatic logic [7:0] alphabet(input logic [GroupBits-1:0] g);
		logic [7:0] c;
		c = 8'h3F;
		case (g)
			5'd26: c = 8'h20;   // space
			5'd27: c = 8'h2E;   // period
			5'd28: c = 8'h2C;   // comma
			5'd29: c = 8'h2D;   // hyphen
			5'd30: c = 8'h27;   // apostrophe
			5'd31: c = 8'h3F;   // question mark
			default: c = 8'h41 + {3'b000, g};
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/pcr_in_if.sv =====
interface pcr_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_char;

	modport source (output valid, output action, output in_char, input ready);
	modport sink (input valid, input action, input in_char, output ready);
endinterface

// ===== rtl/core/pcr_out_if.sv =====
interface pcr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       is_newline;
	logic       last;

	modport source (output valid, output out_char, output is_newline, output last, input ready);
	modport sink (input valid, input out_char, input is_newline, input last, output ready);
endinterface

// ===== rtl/core/pcr_front.sv =====
module pcr_front (
	input  logic          clk,
	input  logic          arst_n,
	pcr_in_if.sink        items,
	output pcr_pkg::req_t push_req,
	output logic          push_valid,
	input  logic          push_ready
);
	import pcr_pkg::*;

	logic [3:0]           pend_bits_q;
	logic [2:0]           pend_cnt_q;
	prefix_code_t         pc;
	logic [11:0]          acc;
	logic [3:0]           cnt;
	logic [11:0]          aligned;
	logic [3:0]           rem;
	logic [4:0]           keep_mask;
	logic [GroupBits-1:0] pad_grp;
	req_t                 req;
	logic                 accept;

	assign items.ready = push_ready;
	assign accept      = items.valid && push_ready;

	// Append code to leftover bits and left-align in a 12-bit window
	always_comb begin
		pc        = code_lookup(items.in_char);
		acc       = (12'(pend_bits_q) << pc.len) | 12'(pc.code);
		cnt       = 4'(pend_cnt_q) + pc.len;
		aligned   = acc << (4'd12 - cnt);
		pad_grp   = 5'({1'b0, pend_bits_q} << (3'd5 - pend_cnt_q));
		if (cnt >= 4'd10) begin
			rem = cnt - 4'd10;
		end else if (cnt >= 4'd5) begin
			rem = cnt - 4'd5;
		end else begin
			rem = cnt;
		end
		keep_mask = (5'd1 << rem) - 5'd1;
	end

	// Classify the item into a request for the back end
	always_comb begin
		req = '{n_res: 2'd0, grp0: aligned[11:7], grp1: aligned[6:2], nl_tail: 1'b0};
		if (items.action) begin
			req.nl_tail = 1'b1;
			if (pend_cnt_q != 3'd0) begin
				req.n_res = 2'd2;
				req.grp0  = pad_grp;
			end else begin
				req.n_res = 2'd1;
			end
		end else if (cnt >= 4'd10) begin
			req.n_res = 2'd2;
		end else if (cnt >= 4'd5) begin
			req.n_res = 2'd1;
		end
	end

	assign push_req   = req;
	assign push_valid = accept && (req.n_res != 2'd0);

	// Leftover accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept) begin
			if (items.action) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= acc[3:0] & keep_mask[3:0];
				pend_cnt_q  <= rem[2:0];
			end
		end
	end

endmodule

// ===== rtl/core/pcr_queue.sv =====
module pcr_queue #(
	parameter int unsigned Depth = pcr_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pcr_pkg::req_t push_req,
	input  logic          push_valid,
	output logic          push_ready,
	output pcr_pkg::req_t pop_req,
	output logic          pop_valid,
	input  logic          pop_ready
);
	import pcr_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	req_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_req    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/pcr_back.sv =====
module pcr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pcr_pkg::req_t pop_req,
	input  logic          pop_valid,
	output logic          pop_ready,
	pcr_out_if.source     results
);
	import pcr_pkg::*;

	logic       idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_nl_q;
	logic       out_last_q;
	logic       load;
	logic       is_final;
	logic       emit_nl;

	assign load      = pop_valid && (!out_valid_q || results.ready);
	assign is_final  = (pop_req.n_res == 2'd1) || idx_q;
	assign emit_nl   = pop_req.nl_tail && is_final;
	assign pop_ready = load && is_final;

	assign results.valid      = out_valid_q;
	assign results.out_char   = out_char_q;
	assign results.is_newline = out_nl_q;
	assign results.last       = out_last_q;

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= emit_nl ? 8'h00 : alphabet(idx_q ? pop_req.grp1 : pop_req.grp0);
			out_nl_q   <= emit_nl;
			out_last_q <= is_final;
		end
	end

	// Result index within the request and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= !is_final;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/prefix_code_repack_5bit_core.sv =====
// Prefix-code repacker: each accepted character is mapped through a fixed prefix code of
// 3 to 8 bits and appended to a small bit accumulator; every complete 5-bit group leaves as
// one character of a 32-entry alphabet, most significant bit first. An end-of-line request
// pads any leftover bits to a final character, then emits a newline result and clears the
// accumulator. Unknown characters produce nothing. Input is accepted every cycle while the
// request queue has room; the single result register delivers one result per cycle while
// the consumer is ready, so an input that yields two results (a long code or an end of
// line with leftover bits) holds the register until both have left.
module prefix_code_repack_5bit_core #(
	parameter int unsigned QueueDepth = pcr_pkg::QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	pcr_in_if.sink    items,
	pcr_out_if.source results
);
	import pcr_pkg::*;

	req_t push_req;
	logic push_valid;
	logic push_ready;
	req_t pop_req;
	logic pop_valid;
	logic pop_ready;

	// Accept and classify
	pcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_req   (push_req),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decoupling queue
	pcr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_req   (push_req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_req    (pop_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Emit results
	pcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_req   (pop_req),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.results   (results)
	);

endmodule
